### design/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, codes and helpers for the keyed set table.
// ----------------------------------------------------------------------------
package kst_pkg;

	localparam int KST_MAX_KEYS      = 16;
	localparam int KST_CODES_PER_KEY = 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_COUNT  = 2'd1,
		OP_INDEX  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// what the result register is loaded with
	typedef enum logic [2:0] {
		RES_ZERO,
		RES_QUERY,
		RES_VALUE,
		RES_DUP,
		RES_BFULL,
		RES_TFULL
	} res_kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOKUP,
		S_KEY_RD,
		S_KEY_CMP,
		S_MISS,
		S_HIT,
		S_CODE_RD,
		S_CODE_CMP,
		S_SLOT_RD,
		S_APPEND,
		S_FIN
	} state_t;

	typedef struct packed {
		logic      load;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      bkt_hit;
		logic      bkt_new;
		logic      append;
		logic      rd_idx;
		logic      res_load;
		res_kind_t res_kind;
	} kst_cmd_t;

	typedef struct packed {
		logic op_ins;
		logic op_cnt;
		logic op_idx;
		logic used_zero;
		logic table_full;
		logic key_hit;
		logic key_last;
		logic fill_zero;
		logic bkt_full;
		logic code_hit;
		logic slot_last;
		logic idx_ok;
		logic out_free;
	} kst_stat_t;

	function automatic logic [3:0] sat_count(input logic [31:0] n);
		logic [3:0] r;
		r = (n > 32'd15) ? 4'd15 : n[3:0];
		return r;
	endfunction

endpackage

### design/kst_ram.sv
// ----------------------------------------------------------------------------
// kst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/kst_ctrl.sv
// ----------------------------------------------------------------------------
// kst_ctrl
// Sequencer: key scan, code scan, append and result handoff.
// ----------------------------------------------------------------------------
module kst_ctrl
	import kst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  kst_stat_t stat,
	output kst_cmd_t  cmd
);

	state_t    state_q, state_nxt;
	res_kind_t kind_q, kind_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= RES_ZERO;
		end else begin
			state_q <= state_nxt;
			kind_q  <= kind_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		kind_nxt  = kind_q;
		cmd       = '0;
		cmd.res_kind = kind_q;
		in_stall  = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_nxt   = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				if (!stat.op_ins && !stat.op_cnt && !stat.op_idx) begin
					kind_nxt  = RES_ZERO;
					state_nxt = S_FIN;
				end else if (stat.used_zero) begin
					state_nxt = S_MISS;
				end else begin
					state_nxt = S_KEY_RD;
				end
			end
			S_KEY_RD: begin
				state_nxt = S_KEY_CMP;
			end
			S_KEY_CMP: begin
				if (stat.key_hit) begin
					cmd.bkt_hit = 1'b1;
					state_nxt   = S_HIT;
				end else if (stat.key_last) begin
					state_nxt = S_MISS;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_nxt   = S_KEY_RD;
				end
			end
			S_MISS: begin
				if (!stat.op_ins) begin
					kind_nxt  = RES_ZERO;
					state_nxt = S_FIN;
				end else if (stat.table_full) begin
					kind_nxt  = RES_TFULL;
					state_nxt = S_FIN;
				end else begin
					cmd.bkt_new = 1'b1;
					state_nxt   = S_APPEND;
				end
			end
			S_HIT: begin
				cmd.cnt_clr = 1'b1;
				if (stat.op_ins) begin
					state_nxt = stat.fill_zero ? S_APPEND : S_CODE_RD;
				end else if (stat.op_idx && stat.idx_ok) begin
					state_nxt = S_SLOT_RD;
				end else begin
					kind_nxt  = RES_QUERY;
					state_nxt = S_FIN;
				end
			end
			S_CODE_RD: begin
				state_nxt = S_CODE_CMP;
			end
			S_CODE_CMP: begin
				if (stat.code_hit) begin
					kind_nxt  = RES_DUP;
					state_nxt = S_FIN;
				end else if (stat.slot_last) begin
					if (stat.bkt_full) begin
						kind_nxt  = RES_BFULL;
						state_nxt = S_FIN;
					end else begin
						state_nxt = S_APPEND;
					end
				end else begin
					cmd.cnt_inc = 1'b1;
					state_nxt   = S_CODE_RD;
				end
			end
			S_SLOT_RD: begin
				cmd.rd_idx = 1'b1;
				kind_nxt   = RES_VALUE;
				state_nxt  = S_FIN;
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				kind_nxt   = RES_QUERY;
				state_nxt  = S_FIN;
			end
			S_FIN: begin
				// hold the slot read address so an indexed value stays put
				cmd.rd_idx = 1'b1;
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

### design/kst_dpath.sv
// ----------------------------------------------------------------------------
// kst_dpath
// Item registers, bucket and slot RAMs, scan counter and result register.
// ----------------------------------------------------------------------------
module kst_dpath
	import kst_pkg::*;
#(
	parameter int MAX_KEYS      = KST_MAX_KEYS,
	parameter int CODES_PER_KEY = KST_CODES_PER_KEY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] key_id,
	input  logic signed [31:0] atom_code,
	input  logic [7:0]         entry_index,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [3:0]         code_count,
	output logic signed [31:0] code_out,
	output logic [1:0]         status,
	input  kst_cmd_t           cmd,
	output kst_stat_t          stat
);

	localparam int KAW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int SOW = (CODES_PER_KEY > 1) ? $clog2(CODES_PER_KEY) : 1;
	localparam int CW  = (KAW > SOW) ? KAW : SOW;
	localparam int FW  = $clog2(CODES_PER_KEY + 1);
	localparam int UW  = $clog2(MAX_KEYS + 1);
	localparam int SD  = MAX_KEYS * CODES_PER_KEY;
	localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
	localparam int BW  = 32 + FW;
	localparam int XA  = (CW > FW) ? CW : FW;
	localparam int XB  = (XA > UW) ? XA : UW;
	localparam int XW  = ((XB > 8) ? XB : 8) + 1;

	logic [1:0]     op_q;
	logic [31:0]    key_q;
	logic [31:0]    code_q;
	logic [7:0]     idx_q;
	logic [CW-1:0]  cnt_q;
	logic [KAW-1:0] bkt_q;
	logic [FW-1:0]  fill_q;
	logic           new_q;
	logic [UW-1:0]  used_q;

	logic           out_valid_q;
	logic [3:0]     count_q;
	logic [31:0]    value_q;
	logic [1:0]     status_q;

	logic [BW-1:0]  bkt_rdata;
	logic [31:0]    rd_key;
	logic [FW-1:0]  rd_fill;
	logic [FW-1:0]  fill_inc;
	logic [31:0]    slot_rdata;
	logic [SAW-1:0] slot_base;
	logic [SAW-1:0] slot_raddr;
	logic [SAW-1:0] slot_waddr;
	logic [3:0]     fill_sat;

	assign {rd_key, rd_fill} = bkt_rdata;
	assign fill_inc  = fill_q + FW'(1);
	assign fill_sat  = sat_count(32'(fill_q));
	assign slot_base = SAW'(bkt_q) * SAW'(CODES_PER_KEY);
	assign slot_raddr = slot_base + (cmd.rd_idx ? SAW'(idx_q) : SAW'(cnt_q));
	assign slot_waddr = slot_base + SAW'(fill_q);

	kst_ram #(
		.WIDTH (BW),
		.DEPTH (MAX_KEYS)
	) u_bkt_ram (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (bkt_q),
		.wdata ({key_q, fill_inc}),
		.raddr (cnt_q[KAW-1:0]),
		.rdata (bkt_rdata)
	);

	kst_ram #(
		.WIDTH (32),
		.DEPTH (SD)
	) u_slot_ram (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (slot_waddr),
		.wdata (code_q),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// item and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			key_q  <= key_id;
			code_q <= atom_code;
			idx_q  <= entry_index;
		end
		if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.bkt_hit) begin
			bkt_q  <= cnt_q[KAW-1:0];
			fill_q <= rd_fill;
			new_q  <= 1'b0;
		end else if (cmd.bkt_new) begin
			bkt_q  <= used_q[KAW-1:0];
			fill_q <= '0;
			new_q  <= 1'b1;
		end else if (cmd.append) begin
			fill_q <= fill_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.append && new_q) begin
				used_q <= used_q + UW'(1);
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_kind)
				RES_QUERY: begin
					count_q  <= fill_sat;
					value_q  <= '0;
					status_q <= ST_OK;
				end
				RES_VALUE: begin
					count_q  <= fill_sat;
					value_q  <= slot_rdata;
					status_q <= ST_OK;
				end
				RES_DUP: begin
					count_q  <= fill_sat;
					value_q  <= '0;
					status_q <= ST_DUP;
				end
				RES_BFULL: begin
					count_q  <= fill_sat;
					value_q  <= '0;
					status_q <= ST_FULL;
				end
				RES_TFULL: begin
					count_q  <= '0;
					value_q  <= '0;
					status_q <= ST_FULL;
				end
				default: begin
					count_q  <= '0;
					value_q  <= '0;
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign code_count = count_q;
	assign code_out   = value_q;
	assign status     = status_q;

	always_comb begin
		stat            = '0;
		stat.op_ins     = (op_q == OP_INSERT);
		stat.op_cnt     = (op_q == OP_COUNT);
		stat.op_idx     = (op_q == OP_INDEX);
		stat.used_zero  = (used_q == '0);
		stat.table_full = (XW'(used_q) >= XW'(MAX_KEYS));
		stat.key_hit    = (rd_key == key_q);
		stat.key_last   = ((XW'(cnt_q) + XW'(1)) >= XW'(used_q));
		stat.fill_zero  = (fill_q == '0);
		stat.bkt_full   = (XW'(fill_q) >= XW'(CODES_PER_KEY));
		stat.code_hit   = (slot_rdata == code_q);
		stat.slot_last  = ((XW'(cnt_q) + XW'(1)) >= XW'(fill_q));
		stat.idx_ok     = (XW'(idx_q) < XW'(fill_q)) && (XW'(idx_q) < XW'(CODES_PER_KEY));
		stat.out_free   = !out_valid_q || !out_stall;
	end

endmodule

### design/keyed_set_table.sv
// ----------------------------------------------------------------------------
// keyed_set_table
// Small key table; each key holds a deduplicated set of codes.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Opcode 0 inserts atom_code under key_id (status
// ok, duplicate, or full when no bucket or slot is left); opcode 1 returns the
// key's code count; opcode 2 returns the code at entry_index, or 0 when the
// key is unknown or the index is past the count; opcode 3 returns all zeros.
// Items are handled one at a time. The key lookup walks the buckets in use
// through a registered-read RAM, a read state and a compare state per bucket,
// and an insert into an existing key then walks its codes the same way.
// The next beat is taken while a finished result still waits in the output
// register. Table contents need no clearing after reset: only buckets below
// the in-use count and slots below a bucket's fill are read.
// ----------------------------------------------------------------------------
module keyed_set_table
	import kst_pkg::*;
#(
	parameter int MAX_KEYS      = KST_MAX_KEYS,
	parameter int CODES_PER_KEY = KST_CODES_PER_KEY
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] key_id,
	input  logic signed [31:0] atom_code,
	input  logic [7:0]         entry_index,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         code_count,
	output logic signed [31:0] code_out,
	output logic [1:0]         status
);

	kst_cmd_t  cmd;
	kst_stat_t stat;

	// sequencer: decides each step from datapath flags
	kst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage, compare logic and result register
	kst_dpath #(
		.MAX_KEYS      (MAX_KEYS),
		.CODES_PER_KEY (CODES_PER_KEY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode      (opcode),
		.key_id      (key_id),
		.atom_code   (atom_code),
		.entry_index (entry_index),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.code_count  (code_count),
		.code_out    (code_out),
		.status      (status),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

### dv/keyed_set_table_tb.sv
// ----------------------------------------------------------------------------
// keyed_set_table_tb
// Self-checking bench: directed rows, then pooled random traffic, all scored.
// ----------------------------------------------------------------------------
// Each accepted request beat is run through a local model of the key table
// and its expected result is queued. Result beats are scored in order,
// field by field. Both channels idle at random. One phase runs with no idling
// at all, and one phase opens with a long receiver hold-off that backs the
// block up into its input.
// ----------------------------------------------------------------------------
module keyed_set_table_tb
	import kst_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  OP_UNUSED    = 2'd3;  // no-op opcode, all-zero result
	localparam logic [31:0] KEY_MAX      = 32'h7FFF_FFFF;
	localparam logic [31:0] KEY_MIN      = 32'h8000_0000;
	localparam int          NEW_KEYS     = 18;    // more than the free buckets left
	localparam int          CODE_CHOICES = 12;    // > CODES_PER_KEY so buckets fill
	localparam int          HOLD_CYCLES  = 400;
	localparam int          DRAIN_CYCLES = 80;
	// The hold-off is the longest quiet stretch.
	localparam int          QUIET_LIMIT  = 4000;

	typedef struct packed {
		logic [3:0]  count;
		logic [31:0] code;
		status_t     status;
	} table_result_t;

	typedef struct {
		logic [1:0]    op;
		logic [31:0]   key;
		logic [31:0]   code;
		logic [7:0]    idx;
		bit            fixed;   // use the typed result instead of the model's
		table_result_t want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         opcode;
	logic signed [31:0] key_id;
	logic signed [31:0] atom_code;
	logic [7:0]         entry_index;
	logic               out_valid;
	logic               out_stall;
	logic [3:0]         code_count;
	logic signed [31:0] code_out;
	logic [1:0]         status;

	keyed_set_table u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.key_id      (key_id),
		.atom_code   (atom_code),
		.entry_index (entry_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_count  (code_count),
		.code_out    (code_out),
		.status      (status)
	);

	// local copy of the key table
	logic [31:0] tbl_key  [KST_MAX_KEYS];
	logic [3:0]  tbl_fill [KST_MAX_KEYS];
	logic [31:0] tbl_code [KST_MAX_KEYS][KST_CODES_PER_KEY];
	int          keys_in_use = 0;

	table_result_t pending_results[$];   // one entry per beat taken, oldest first
	stim_row_t     directed_rows[$];
	logic [31:0]   key_pool[$];
	logic [31:0]   code_pool[CODE_CHOICES];

	int mismatch_count = 0;
	int quiet_cycles   = 0;
	bit calm           = 1'b0;   // no idling on either side while set
	bit hold_req       = 1'b0;   // asks the receiver for one long hold-off

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one request to the local table and returns its result.
	function automatic table_result_t apply_to_table(input logic [1:0] op,
			input logic [31:0] key, input logic [31:0] code, input logic [7:0] idx);
		table_result_t r;
		int            b;
		int            n;
		bit            dup;
		r = '{count: 4'd0, code: 32'd0, status: ST_OK};
		b = -1;
		for (int i = 0; i < keys_in_use; i++)
			if (b < 0 && tbl_key[i] == key) b = i;
		case (op)
			OP_INSERT: begin
				// absent key: open the next bucket if one is left
				if (b < 0 && keys_in_use < KST_MAX_KEYS) begin
					b = keys_in_use;
					tbl_key[b] = key;
					tbl_fill[b] = 4'd0;
					keys_in_use++;
				end
				if (b < 0) begin
					r.status = ST_FULL;   // no bucket free, count stays 0
				end else begin
					n = tbl_fill[b];
					dup = 1'b0;
					for (int i = 0; i < n; i++)
						if (tbl_code[b][i] == code) dup = 1'b1;
					// duplicate is checked before the slot limit
					if (dup) begin
						r.status = ST_DUP;
					end else if (n >= KST_CODES_PER_KEY) begin
						r.status = ST_FULL;
					end else begin
						tbl_code[b][n] = code;
						tbl_fill[b] = 4'(n + 1);
					end
					r.count = tbl_fill[b];
				end
			end
			OP_COUNT, OP_INDEX: begin
				if (b >= 0) begin
					r.count = tbl_fill[b];
					if (op == OP_INDEX && idx < tbl_fill[b]) r.code = tbl_code[b][idx];
				end
			end
			default: ;   // unused opcode: nothing changes, all fields zero
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Offers one request beat and holds it until taken. Gaps come first, so a
	// valid that stays high between beats gets only one assignment per edge.
	task automatic send_beat(input logic [1:0] op, input logic [31:0] key,
			input logic [31:0] code, input logic [7:0] idx, input bit fixed,
			input table_result_t want);
		table_result_t r;
		while (!calm && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		key_id      <= key;
		atom_code   <= code;
		entry_index <= idx;
		do @(posedge clk); while (in_stall);
		r = apply_to_table(op, key, code, idx);   // keeps the table in step
		pending_results.push_back(fixed ? want : r);
	endtask

	task automatic add_row(input logic [1:0] op, input logic [31:0] key,
			input logic [31:0] code, input logic [7:0] idx, input bit fixed,
			input logic [3:0] cnt, input logic [31:0] val, input status_t st);
		stim_row_t row;
		row.op          = op;
		row.key         = key;
		row.code        = code;
		row.idx         = idx;
		row.fixed       = fixed;
		row.want.count  = cnt;
		row.want.code   = val;
		row.want.status = st;
		directed_rows.push_back(row);
	endtask

	// Random traffic. Well-formed beats use pooled keys and codes so that hits,
	// duplicates and full buckets are common. Noise beats carry raw random
	// fields, the unused opcode included.
	task automatic send_random(input int beats, input bit noisy);
		logic [1:0]  op;
		logic [31:0] key;
		logic [31:0] code;
		logic [7:0]  idx;
		int          pick;
		for (int i = 0; i < beats; i++) begin
			if (noisy && $urandom_range(0, 99) < 20) begin
				op   = 2'($urandom_range(0, 3));
				key  = $urandom;
				code = $urandom;
				idx  = 8'($urandom_range(0, 255));
			end else begin
				pick = $urandom_range(0, 99);
				op   = (pick < 45) ? OP_INSERT : (pick < 65) ? OP_COUNT : OP_INDEX;
				key  = key_pool[$urandom_range(0, key_pool.size() - 1)];
				code = ($urandom_range(0, 9) == 0) ? $urandom
					: code_pool[$urandom_range(0, CODE_CHOICES - 1)];
				// mostly around the fill level, sometimes far past it
				idx  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 9));
			end
			send_beat(op, key, code, idx, 1'b0, '0);
		end
	endtask

	// Receiver: random stalls, or one long hold-off on request.
	initial begin
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 28);
			end
		end
	end

	// Result scoreboard, plus the count of cycles with no beat on either side.
	initial begin
		table_result_t want;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (arst_n && out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result (code_count)", 32'(code_count), 32'd0);
				end else begin
					want = pending_results.pop_front();
					if (code_count !== want.count)
						report_mismatch("code_count", 32'(code_count), 32'(want.count));
					if (code_out !== want.code)
						report_mismatch("code_out", code_out, want.code);
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
				end
			end
		end
	end

	// watchdog
	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("[keyed_set_table] ERROR");
		$finish;
	end

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		opcode      <= OP_INSERT;
		key_id      <= '0;
		atom_code   <= '0;
		entry_index <= '0;

		// Pools: the two extreme keys from the directed rows plus fresh
		// random ones, more than the buckets that will be left.
		key_pool.push_back(KEY_MAX);
		key_pool.push_back(KEY_MIN);
		for (int i = 0; i < NEW_KEYS; i++) key_pool.push_back($urandom);
		code_pool[0] = 32'd0;
		code_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < CODE_CHOICES; i++) code_pool[i] = $urandom;

		// Directed rows. Typed results where obvious, the model elsewhere.
		// empty table: both queries miss, the unused opcode returns zeros
		add_row(OP_COUNT,  32'd0,   32'd0,   8'd0,   1, 4'd0, 32'd0, ST_OK);
		add_row(OP_INDEX,  KEY_MIN, 32'd0,   8'd255, 1, 4'd0, 32'd0, ST_OK);
		add_row(OP_UNUSED, '1,      '1,      8'd255, 1, 4'd0, 32'd0, ST_OK);
		// first insert opens a bucket, repeating it is a duplicate
		add_row(OP_INSERT, KEY_MAX, KEY_MIN, 8'd0,   1, 4'd1, 32'd0, ST_OK);
		add_row(OP_INSERT, KEY_MAX, KEY_MIN, 8'd0,   1, 4'd1, 32'd0, ST_DUP);
		add_row(OP_INSERT, KEY_MAX, KEY_MAX, 8'd0,   1, 4'd2, 32'd0, ST_OK);
		add_row(OP_INSERT, KEY_MIN, 32'd0,   8'd0,   1, 4'd1, 32'd0, ST_OK);
		// fill the KEY_MAX bucket to its last slot
		for (int c = 1; c <= 6; c++)
			add_row(OP_INSERT, KEY_MAX, 32'(c), 8'd0, 0, 4'd0, 32'd0, ST_OK);
		// bucket full drops a new code, but a held code still reads as duplicate
		add_row(OP_INSERT, KEY_MAX, '1,      8'd0,   1, 4'd8, 32'd0, ST_FULL);
		add_row(OP_INSERT, KEY_MAX, 32'd3,   8'd0,   1, 4'd8, 32'd0, ST_DUP);
		add_row(OP_COUNT,  KEY_MAX, 32'd0,   8'd0,   1, 4'd8, 32'd0, ST_OK);
		add_row(OP_INDEX,  KEY_MAX, 32'd0,   8'd0,   1, 4'd8, KEY_MIN, ST_OK);
		add_row(OP_INDEX,  KEY_MAX, 32'd0,   8'd7,   0, 4'd0, 32'd0, ST_OK);
		// index at the count and at the top of the field: out of range
		add_row(OP_INDEX,  KEY_MAX, 32'd0,   8'd8,   1, 4'd8, 32'd0, ST_OK);
		add_row(OP_INDEX,  KEY_MAX, 32'd0,   8'd255, 1, 4'd8, 32'd0, ST_OK);
		add_row(OP_INDEX,  KEY_MIN, 32'd0,   8'd0,   0, 4'd0, 32'd0, ST_OK);
		// unknown key with a populated table, unused opcode on a known key
		add_row(OP_COUNT,  32'd1,   32'd0,   8'd0,   1, 4'd0, 32'd0, ST_OK);
		add_row(OP_UNUSED, KEY_MAX, KEY_MAX, 8'd1,   1, 4'd0, 32'd0, ST_OK);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].op, directed_rows[i].key, directed_rows[i].code,
				directed_rows[i].idx, directed_rows[i].fixed, directed_rows[i].want);

		// Sender pauses until every result has come back.
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);

		// Back-to-back stretch. One insert per fresh key runs the table out of
		// buckets: the last few keys are dropped as table full.
		calm = 1'b1;
		for (int i = 2; i < key_pool.size(); i++)
			send_beat(OP_INSERT, key_pool[i], code_pool[i % CODE_CHOICES], 8'd0, 1'b0, '0);
		send_random(300, 1'b0);
		calm = 1'b0;

		// Long receiver hold-off while requests keep coming: the block backs up.
		hold_req = 1'b1;
		send_random(800, 1'b1);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		send_random(780, 1'b1);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("[keyed_set_table] OK");
		end else begin
			$display("[keyed_set_table] ERROR");
		end
		$finish;
	end

endmodule
